FILE: rtl/tcw_pkg.sv
// tcw_pkg: field widths, codes and controller/datapath command and status types
// for the text console writer. No dependencies.

package tcw_pkg;

  localparam int REQ_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int CELL_W    = 16;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;
  localparam int ATTR_W    = 8;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd14;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_ZERO,
    CNT_BLANK_START,
    CNT_INC
  } cnt_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_COPY,
    ST_BLANK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic put_exec;
    logic read_issue;
    logic home;
    logic copy_step;
    logic blank_write;
    logic load_rsp;
    logic rsp_sel_ram;
    cnt_e cnt_op;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             scroll_needed;
    logic             index_ok;
    logic             cnt_copy_last;
    logic             cnt_last;
  } status_t;

endpackage

FILE: rtl/tcw_if.sv
// tcw_if: valid/ready channel interfaces for requests and results.
// Depends on tcw_pkg for field widths.

interface tcw_req_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::REQ_W-1:0]     req_type;
  logic [tcw_pkg::CHAR_W-1:0]    char_code;
  logic [tcw_pkg::INDEX_W-1:0]   cell_index;

  modport source (output valid, req_type, char_code, cell_index, input ready);
  modport sink   (input valid, req_type, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [tcw_pkg::CELL_W-1:0]      read_data;
  logic [tcw_pkg::ROW_OUT_W-1:0]   cursor_row;
  logic [tcw_pkg::COL_OUT_W-1:0]   cursor_col;
  logic                            scrolled;

  modport source (output valid, read_data, cursor_row, cursor_col, scrolled, input ready);
  modport sink   (input valid, read_data, cursor_row, cursor_col, scrolled, output ready);
endinterface

FILE: rtl/tcw_ram.sv
// tcw_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/tcw_datapath.sv
// tcw_datapath: cursor, attribute, request and result registers, sweep counter
// and screen RAM. Depends on tcw_pkg and tcw_ram.

module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0]      cfg_wdata_i,
  input  logic [tcw_pkg::REQ_W-1:0]       req_type_i,
  input  logic [tcw_pkg::CHAR_W-1:0]      char_code_i,
  input  logic [tcw_pkg::INDEX_W-1:0]     cell_index_i,
  input  tcw_pkg::cmd_t                   cmd_i,
  output tcw_pkg::status_t                status_o,
  output logic [tcw_pkg::CELL_W-1:0]      read_data_o,
  output logic [tcw_pkg::ROW_OUT_W-1:0]   cursor_row_o,
  output logic [tcw_pkg::COL_OUT_W-1:0]   cursor_col_o,
  output logic                            scrolled_o
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);

  localparam logic [AW-1:0] COPY_LAST = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);

  logic [ATTR_W-1:0]  attr_q, attr_d;
  logic [RW-1:0]      row_q, row_d;
  logic [CW-1:0]      col_q, col_d;
  logic               scroll_q, scroll_d;
  logic [AW-1:0]      cnt_q, cnt_d;
  logic [REQ_W-1:0]   req_q;
  logic [CHAR_W-1:0]  code_q;
  logic [INDEX_W-1:0] index_q;
  logic [CELL_W-1:0]  rsp_data_q;
  logic [RW-1:0]      rsp_row_q;
  logic [CW-1:0]      rsp_col_q;
  logic               rsp_scroll_q;

  logic               is_nl, line_end, last_row, scroll_needed;
  logic [AW-1:0]      pos;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [CELL_W-1:0]  ram_wdata, ram_rdata;

  assign is_nl         = (code_q == NEWLINE_CODE);
  assign line_end      = is_nl || (col_q == COL_LAST);
  assign last_row      = (row_q == ROW_LAST);
  assign scroll_needed = line_end && last_row;
  assign pos           = AW'(row_q) * ROW_STEP + AW'(col_q);

  always_comb begin
    attr_d   = cfg_we_i ? cfg_wdata_i : attr_q;
    row_d    = row_q;
    col_d    = col_q;
    scroll_d = scroll_q;
    if (cmd_i.capture) begin
      scroll_d = 1'b0;
    end
    if (cmd_i.put_exec) begin
      scroll_d = scroll_needed;
      if (line_end) begin
        col_d = '0;
        if (!last_row) begin
          row_d = row_q + RW'(1);
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
    if (cmd_i.home) begin
      row_d = '0;
      col_d = '0;
    end
    case (cmd_i.cnt_op)
      CNT_HOLD:        cnt_d = cnt_q;
      CNT_ZERO:        cnt_d = '0;
      CNT_BLANK_START: cnt_d = COPY_LAST;
      CNT_INC:         cnt_d = cnt_q + AW'(1);
      default:         cnt_d = cnt_q;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = {attr_q, BLANK_CODE};
    ram_re    = 1'b0;
    ram_raddr = cnt_q + ROW_STEP;
    if (cmd_i.put_exec && !is_nl) begin
      ram_we    = 1'b1;
      ram_waddr = pos;
      ram_wdata = {attr_q, code_q};
    end
    // scroll copy: read row below at cnt, write the previous read at cnt-1
    if (cmd_i.copy_step) begin
      ram_re    = (cnt_q != COPY_LAST);
      ram_we    = (cnt_q != '0);
      ram_waddr = cnt_q - AW'(1);
      ram_wdata = ram_rdata;
    end
    if (cmd_i.blank_write) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_q;
    end
    if (cmd_i.read_issue) begin
      ram_re    = 1'b1;
      ram_raddr = AW'(index_q);
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q   <= ATTR_RESET;
      row_q    <= '0;
      col_q    <= '0;
      scroll_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      attr_q   <= attr_d;
      row_q    <= row_d;
      col_q    <= col_d;
      scroll_q <= scroll_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= req_type_i;
      code_q  <= char_code_i;
      index_q <= cell_index_i;
    end
    if (cmd_i.load_rsp) begin
      rsp_data_q   <= cmd_i.rsp_sel_ram ? ram_rdata : '0;
      rsp_row_q    <= row_d;
      rsp_col_q    <= col_d;
      rsp_scroll_q <= scroll_d;
    end
  end

  assign status_o.req           = req_q;
  assign status_o.scroll_needed = scroll_needed;
  assign status_o.index_ok      = (32'(index_q) < CELLS);
  assign status_o.cnt_copy_last = (cnt_q == COPY_LAST);
  assign status_o.cnt_last      = (cnt_q == CELL_LAST);

  assign read_data_o  = rsp_data_q;
  assign cursor_row_o = ROW_OUT_W'(rsp_row_q);
  assign cursor_col_o = COL_OUT_W'(rsp_col_q);
  assign scrolled_o   = rsp_scroll_q;

endmodule

FILE: rtl/tcw_ctrl.sv
// tcw_ctrl: request sequencer; drives datapath commands and the handshakes.
// Depends on tcw_pkg.

module tcw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tcw_pkg::status_t  status_i,
  output tcw_pkg::cmd_t     cmd_o
);
  import tcw_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.cnt_op = CNT_HOLD;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.req == REQ_PUT) begin
          if (status_i.scroll_needed) begin
            cmd_o.put_exec = 1'b1;
            cmd_o.cnt_op   = CNT_ZERO;
            state_d        = ST_COPY;
          end else if (out_free) begin
            cmd_o.put_exec = 1'b1;
            cmd_o.load_rsp = 1'b1;
            state_d        = ST_IDLE;
          end
        end else if (status_i.req == REQ_READ) begin
          if (status_i.index_ok) begin
            cmd_o.read_issue = 1'b1;
            state_d          = ST_READ;
          end else if (out_free) begin
            cmd_o.load_rsp = 1'b1;
            state_d        = ST_IDLE;
          end
        end else if (status_i.req == REQ_CLEAR) begin
          cmd_o.home   = 1'b1;
          cmd_o.cnt_op = CNT_ZERO;
          state_d      = ST_BLANK;
        end else if (out_free) begin
          cmd_o.load_rsp = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free) begin
          cmd_o.load_rsp    = 1'b1;
          cmd_o.rsp_sel_ram = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_COPY: begin
        cmd_o.copy_step = 1'b1;
        if (status_i.cnt_copy_last) begin
          cmd_o.cnt_op = CNT_BLANK_START;
          state_d      = ST_BLANK;
        end else begin
          cmd_o.cnt_op = CNT_INC;
        end
      end
      ST_BLANK: begin
        cmd_o.blank_write = 1'b1;
        if (status_i.cnt_last) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.cnt_op = CNT_INC;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_rsp = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_rsp) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/text_console_writer.sv
// text_console_writer: text console screen writer, top level.
// Depends on tcw_pkg, tcw_if, tcw_ctrl, tcw_datapath and tcw_ram.
//
//   channel  dir  handshake        payload
//   req_i    in   valid/ready      req_type, char_code, cell_index
//   rsp_o    out  valid/ready      read_data, cursor_row, cursor_col, scrolled
//   cfg      in   cfg_we_i         cfg_wdata_i (attribute)
//
// One request at a time; a put without scroll runs through ST_EXEC, a read through
// ST_EXEC and ST_READ. Scroll runs a RAM copy sweep of COLUMNS*(ROWS-1) cells plus
// COLUMNS blank writes; clear writes COLUMNS*ROWS blanks from the top-left cell.
// Reset homes the cursor and loads ATTR_RESET into the attribute; screen RAM is undefined until written.
// A new request is taken while a result waits; its result waits for rsp_o.

module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wdata_i,
  tcw_req_if.sink                     req_i,
  tcw_rsp_if.source                   rsp_o
);
  import tcw_pkg::*;

  cmd_t    cmd;
  status_t status;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_type_i   (req_i.req_type),
    .char_code_i  (req_i.char_code),
    .cell_index_i (req_i.cell_index),
    .cmd_i        (cmd),
    .status_o     (status),
    .read_data_o  (rsp_o.read_data),
    .cursor_row_o (rsp_o.cursor_row),
    .cursor_col_o (rsp_o.cursor_col),
    .scrolled_o   (rsp_o.scrolled)
  );

endmodule

FILE: sim/text_console_writer_tb.sv
// text_console_writer_tb: self-checking testbench for the text console writer.
// Depends on tcw_pkg, tcw_if and the text_console_writer RTL; a scoreboard class
// tracks screen, cursor and attribute and checks every result transaction.

module text_console_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [CELL_W-1:0]    read_data;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;
    logic                 scrolled;
  } console_result_t;

  class console_scoreboard;
    logic [CELL_W-1:0] cells [CELLS];
    bit                written [CELLS];
    int unsigned       row;
    int unsigned       col;
    logic [ATTR_W-1:0] attr;
    console_result_t   expected_q [$];
    int unsigned       errors;

    function new();
      row    = 0;
      col    = 0;
      attr   = ATTR_RESET;
      errors = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function bit readable(int unsigned idx);
      return (idx >= CELLS) || written[idx];
    endfunction

    // cursor to start of next row; scrolls when stepping off the last row
    function bit next_line();
      col = 0;
      row++;
      if (row < ROWS) return 1'b0;
      for (int i = 0; i < CELLS - COLUMNS; i++) begin
        cells[i]   = cells[i + COLUMNS];
        written[i] = written[i + COLUMNS];
      end
      for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
        cells[i]   = {attr, BLANK_CODE};
        written[i] = 1'b1;
      end
      row = ROWS - 1;
      return 1'b1;
    endfunction

    function void note_request(logic [REQ_W-1:0] kind, logic [CHAR_W-1:0] code,
                               logic [INDEX_W-1:0] idx);
      console_result_t exp;
      int unsigned     pos;
      exp = '0;
      if (kind == REQ_PUT) begin
        if (code == NEWLINE_CODE) begin
          exp.scrolled = next_line();
        end else begin
          pos = row * COLUMNS + col;
          if (pos < CELLS) begin
            cells[pos]   = {attr, code};
            written[pos] = 1'b1;
          end
          col++;
          if (col >= COLUMNS) exp.scrolled = next_line();
        end
      end else if (kind == REQ_READ) begin
        if (idx < CELLS) exp.read_data = cells[idx];
      end else if (kind == REQ_CLEAR) begin
        for (int i = 0; i < CELLS; i++) begin
          cells[i]   = {attr, BLANK_CODE};
          written[i] = 1'b1;
        end
        row = 0;
        col = 0;
      end
      exp.cursor_row = ROW_OUT_W'(row);
      exp.cursor_col = COL_OUT_W'(col);
      expected_q.push_back(exp);
    endfunction

    function void check_result(console_result_t got);
      console_result_t exp;
      if (expected_q.size() == 0) begin
        $error("unexpected result: read_data %h, cursor %0d/%0d, scrolled %0b",
               got.read_data, got.cursor_row, got.cursor_col, got.scrolled);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.read_data !== exp.read_data) begin
        $error("read_data: expected %h, actual %h", exp.read_data, got.read_data);
        errors++;
      end
      if (got.cursor_row !== exp.cursor_row) begin
        $error("cursor_row: expected %0d, actual %0d", exp.cursor_row, got.cursor_row);
        errors++;
      end
      if (got.cursor_col !== exp.cursor_col) begin
        $error("cursor_col: expected %0d, actual %0d", exp.cursor_col, got.cursor_col);
        errors++;
      end
      if (got.scrolled !== exp.scrolled) begin
        $error("scrolled: expected %0b, actual %0b", exp.scrolled, got.scrolled);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  logic [ATTR_W-1:0] cfg_wdata;
  bit                idle_enabled;
  int unsigned       stall_left;
  int unsigned       cycles;
  console_scoreboard board;

  tcw_req_if req_if ();
  tcw_rsp_if rsp_if ();

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result monitor and ready stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        board.check_result({rsp_if.read_data, rsp_if.cursor_row, rsp_if.cursor_col,
                            rsp_if.scrolled});
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (idle_enabled && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [CHAR_W-1:0] code,
                              input logic [INDEX_W-1:0] idx);
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= kind;
    req_if.char_code  <= code;
    req_if.cell_index <= idx;
    do @(posedge clk_i); while (!req_if.ready);
    board.note_request(kind, code, idx);
  endtask

  // attribute changes only with the block idle
  task automatic set_attribute(input logic [ATTR_W-1:0] value);
    req_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    board.attr = value;
  endtask

  task automatic run_random(input int unsigned quota);
    int unsigned        sent;
    int unsigned        pick;
    int unsigned        burst;
    logic [CHAR_W-1:0]  code;
    logic [INDEX_W-1:0] idx;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(0, 99);
      code = CHAR_W'($urandom);
      idx  = INDEX_W'($urandom);
      if (pick < 3) begin
        // long text run to force wraps
        burst = $urandom_range(60, 100);
        for (int k = 0; k < burst; k++) begin
          code = CHAR_W'($urandom);
          if (code == NEWLINE_CODE) code = 8'h41;
          send_request(REQ_PUT, code, INDEX_W'($urandom));
        end
        sent += burst;
      end else begin
        if (pick < 11) begin
          send_request(REQ_PUT, NEWLINE_CODE, idx);
        end else if (pick < 60 || pick >= 94) begin
          send_request(REQ_PUT, code, idx);
        end else if (pick < 84) begin
          idx = INDEX_W'($urandom_range(0, CELLS - 1));
          if (!board.readable(idx)) idx = INDEX_W'($urandom_range(CELLS, 2047));
          send_request(REQ_READ, code, idx);
        end else if (pick < 88) begin
          send_request(REQ_READ, code, INDEX_W'($urandom_range(CELLS, 2047)));
        end else if (pick < 92) begin
          send_request(REQ_UNUSED, code, idx);
        end else begin
          send_request(REQ_CLEAR, code, idx);
        end
        sent++;
      end
    end
  endtask

  initial begin
    board             = new();
    cycles            = 0;
    stall_left        = 0;
    idle_enabled      = 1'b1;
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    req_if.valid      = 1'b0;
    req_if.req_type   = '0;
    req_if.char_code  = '0;
    req_if.cell_index = '0;
    rsp_if.ready      = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset attribute, field extremes, all request codes
    send_request(REQ_PUT, 8'h41, 11'h7FF);
    send_request(REQ_PUT, 8'h00, 11'h000);
    send_request(REQ_PUT, 8'hFF, 11'h7FF);
    send_request(REQ_READ, 8'hFF, 11'd0);
    send_request(REQ_READ, 8'h00, 11'd2);
    send_request(REQ_READ, 8'h00, 11'd2000);
    send_request(REQ_READ, 8'hFF, 11'h7FF);
    send_request(REQ_UNUSED, 8'hFF, 11'h7FF);
    send_request(REQ_PUT, NEWLINE_CODE, 11'd0);
    send_request(REQ_PUT, 8'h7F, 11'd0);
    send_request(REQ_READ, 8'h00, 11'd80);
    send_request(REQ_CLEAR, 8'h00, 11'd0);
    send_request(REQ_READ, 8'h00, 11'd1999);
    send_request(REQ_READ, 8'h00, 11'd0);
    send_request(REQ_PUT, 8'h80, 11'd0);
    send_request(REQ_READ, 8'h00, 11'd0);

    set_attribute(8'h00);
    send_request(REQ_CLEAR, 8'h00, 11'd0);
    run_random(PHASE_ITEMS);
    set_attribute(8'hFF);
    run_random(PHASE_ITEMS);
    set_attribute(ATTR_W'($urandom));
    run_random(PHASE_ITEMS);
    set_attribute(ATTR_W'($urandom));
    run_random(PHASE_ITEMS);
    set_attribute(ATTR_W'($urandom));
    idle_enabled = 1'b0;
    run_random(PHASE_ITEMS);

    req_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tcw_pkg.sv
rtl/tcw_if.sv
rtl/tcw_ram.sv
rtl/tcw_datapath.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer.sv
sim/text_console_writer_tb.sv
